// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scanner check failed");

// Next-cycle implication, off while reset is held.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scanner check failed");

// Next-cycle implication that also runs through reset.
`define STS_ASSERT_NEXT_NORST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// ----- src/sts_pkg.sv -----
package sts_pkg;

    // Counter and field widths
    localparam int OFFSET_WIDTH    = 16;
    localparam int KEYWORD_MAX_LEN = 6;
    localparam int PIX_W           = $clog2(KEYWORD_MAX_LEN);
    localparam int OUT_W           = 16;
    localparam int IN_DATA_W       = 8;
    localparam int IN_USER_W       = 1;
    localparam int KIND_W          = 6;
    localparam int ERR_W           = 2;
    localparam int OUT_DATA_W      = 3 * OUT_W;
    localparam int OUT_USER_W      = KIND_W + ERR_W;

    // Result queue sizing
    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = FIFO_AW + 1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_LPAREN       = 6'd0;
    localparam logic [KIND_W-1:0] K_RPAREN       = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACE       = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACE       = 6'd3;
    localparam logic [KIND_W-1:0] K_COMMA        = 6'd4;
    localparam logic [KIND_W-1:0] K_DOT          = 6'd5;
    localparam logic [KIND_W-1:0] K_MINUS        = 6'd6;
    localparam logic [KIND_W-1:0] K_PLUS         = 6'd7;
    localparam logic [KIND_W-1:0] K_SEMI         = 6'd8;
    localparam logic [KIND_W-1:0] K_SLASH        = 6'd9;
    localparam logic [KIND_W-1:0] K_STAR         = 6'd10;
    localparam logic [KIND_W-1:0] K_OPER_BASE    = 6'd11;
    localparam logic [KIND_W-1:0] K_IDENT        = 6'd19;
    localparam logic [KIND_W-1:0] K_STRING       = 6'd20;
    localparam logic [KIND_W-1:0] K_NUMBER       = 6'd21;
    localparam logic [KIND_W-1:0] K_KEYWORD_BASE = 6'd22;
    localparam logic [KIND_W-1:0] K_ERROR        = 6'd38;
    localparam logic [KIND_W-1:0] K_EOF          = 6'd39;

    // Error codes
    localparam logic [ERR_W-1:0] E_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] E_UNEXPECTED = 2'd1;
    localparam logic [ERR_W-1:0] E_BAD_NUMBER = 2'd2;
    localparam logic [ERR_W-1:0] E_OPEN_STR   = 2'd3;

endpackage

// ----- src/script_token_scanner_top.sv -----
// Streaming lexical scanner: one source byte per request on the slave side, with
// tuser high for the closing end request, and tokens (kind, error code, start offset,
// length, line) on the master side, tlast on the last token a request caused. A byte
// request is taken every cycle while the slave side is ready: it lands in an input
// register, a single pass of scan logic updates the scanner state and writes zero, one
// or two tokens into an eight-entry result queue, and the first token shows on the
// master side from the queue head. The slave side stays ready while the queue holds
// four tokens or fewer, so the sustained rate is one byte per cycle as long as the
// master side drains one token per cycle; the queue's single read port is the limit
// when bytes produce tokens faster than that. No clearing pass is needed after reset.
module script_token_scanner_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [7:0] source_byte
    input  logic [sts_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // [0] end_of_source
    input  logic [sts_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] start_offset, [31:16] token_length, [47:32] line_number
    output logic [sts_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [5:0] token_kind, [7:6] error_code
    output logic [sts_pkg::OUT_USER_W-1:0] o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import sts_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_SLASH,
        M_COMMENT,
        M_OPER,
        M_STRING,
        M_IDENT,
        M_NUMBER,
        M_NUMBER_DOT
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  len;
        logic [OUT_W-1:0]  line;
        logic              last;
    } t_token;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        t_mode             mode;
        logic [1:0]        pend;
        logic              set_prefix;
        logic              clr_dot;
    } t_disp;

    typedef logic [7:0] t_prefix [KEYWORD_MAX_LEN];

    localparam int EXT_W = OFFSET_WIDTH + OUT_W;
    localparam int NKW   = 16;

    // Pending comparison operator codes
    localparam logic [1:0] OP_BANG    = 2'd0;
    localparam logic [1:0] OP_EQUAL   = 2'd1;
    localparam logic [1:0] OP_GREATER = 2'd2;
    localparam logic [1:0] OP_LESS    = 2'd3;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_HT = 8'h09;

    // Keywords, right-aligned: the last letter sits in the low byte
    localparam logic [63:0] KW_TEXT [NKW] = '{
        64'("and"), 64'("class"), 64'("else"), 64'("false"),
        64'("for"), 64'("fun"), 64'("if"), 64'("nil"),
        64'("or"), 64'("print"), 64'("return"), 64'("super"),
        64'("this"), 64'("true"), 64'("var"), 64'("while")
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3,
        4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
    };

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [OFFSET_WIDTH-1:0] inc_sat(input logic [OFFSET_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] clip_off(input logic [OFFSET_WIDTH-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        if (w > EXT_W'({OUT_W{1'b1}})) begin
            return '1;
        end
        return w[OUT_W-1:0];
    endfunction

    function automatic t_token mk_token(input logic [KIND_W-1:0] kind,
                                        input logic [ERR_W-1:0] err,
                                        input logic [OFFSET_WIDTH-1:0] start,
                                        input logic [OFFSET_WIDTH-1:0] len,
                                        input logic [OUT_W-1:0] line);
        t_token t;
        t.kind  = kind;
        t.err   = err;
        t.start = clip_off(start);
        t.len   = clip_off(len);
        t.line  = line;
        t.last  = 1'b0;
        return t;
    endfunction

    // Match the stored word against the keyword list, all entries side by side
    function automatic logic [KIND_W-1:0] ident_kind(input t_prefix pfx,
                                                     input logic [OFFSET_WIDTH-1:0] len);
        logic [KIND_W-1:0] k;
        logic              hit;
        int                ix;
        k = K_IDENT;
        if (len <= OFFSET_WIDTH'(KEYWORD_MAX_LEN)) begin
            for (int i = 0; i < NKW; i++) begin
                hit = (len == OFFSET_WIDTH'(KW_LEN[i]));
                for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                    ix = int'(KW_LEN[i]) - 1 - j;
                    if (j < int'(KW_LEN[i]) && pfx[j] != KW_TEXT[i][8*ix +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    k = KIND_W'(K_KEYWORD_BASE + KIND_W'(i));
                end
            end
        end
        return k;
    endfunction

    // Scan a byte that arrives between tokens
    function automatic t_disp dispatch(input logic [7:0] b);
        t_disp d;
        d.emit       = 1'b0;
        d.kind       = K_ERROR;
        d.err        = E_NONE;
        d.mode       = M_IDLE;
        d.pend       = OP_BANG;
        d.set_prefix = 1'b0;
        d.clr_dot    = 1'b0;
        case (b)
            " ", CH_CR, CH_LF, CH_HT: begin
                d.emit = 1'b0;
            end
            "(": begin d.emit = 1'b1; d.kind = K_LPAREN; end
            ")": begin d.emit = 1'b1; d.kind = K_RPAREN; end
            "{": begin d.emit = 1'b1; d.kind = K_LBRACE; end
            "}": begin d.emit = 1'b1; d.kind = K_RBRACE; end
            ",": begin d.emit = 1'b1; d.kind = K_COMMA; end
            ".": begin d.emit = 1'b1; d.kind = K_DOT; end
            "-": begin d.emit = 1'b1; d.kind = K_MINUS; end
            "+": begin d.emit = 1'b1; d.kind = K_PLUS; end
            ";": begin d.emit = 1'b1; d.kind = K_SEMI; end
            "*": begin d.emit = 1'b1; d.kind = K_STAR; end
            "/": d.mode = M_SLASH;
            "!": begin d.mode = M_OPER; d.pend = OP_BANG; end
            "=": begin d.mode = M_OPER; d.pend = OP_EQUAL; end
            ">": begin d.mode = M_OPER; d.pend = OP_GREATER; end
            "<": begin d.mode = M_OPER; d.pend = OP_LESS; end
            "\"": d.mode = M_STRING;
            default: begin
                if (is_alpha(b)) begin
                    d.mode       = M_IDENT;
                    d.set_prefix = 1'b1;
                end else if (is_digit(b)) begin
                    d.mode    = M_NUMBER;
                    d.clr_dot = 1'b1;
                end else begin
                    d.emit = 1'b1;
                    d.kind = K_ERROR;
                    d.err  = E_UNEXPECTED;
                end
            end
        endcase
        return d;
    endfunction

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;

    // Scanner state
    t_mode                   r_mode, n_mode;
    logic                    r_dot, n_dot;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [OFFSET_WIDTH-1:0] r_len, n_len;
    logic [OUT_W-1:0]        r_line, n_line;
    t_prefix                 r_prefix, n_prefix;
    logic [1:0]              r_pend, n_pend;

    // Result queue
    t_token             r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic               s_accept, m_pop;
    t_disp              disp;
    logic [KIND_W-1:0]  opk, idk;
    logic               a_vld, b_vld, do_disp;
    t_token             a_tok, b_tok, res0, res1, head;
    logic [1:0]         n_res;
    logic [FIFO_AW-1:0] wr_ptr1;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_count <= CNT_W'(FIFO_DEPTH - 2 * MAX_RESULTS));
    assign m_pop           = o_m_axis_tvalid && i_m_axis_tready;

    assign disp = dispatch(r_in_byte);
    assign opk  = K_OPER_BASE + {3'b000, r_pend, 1'b0};
    assign idk  = ident_kind(r_prefix, r_len);

    // Scan one byte: extend the open token, or flush it and start the next one
    always_comb begin
        n_mode   = r_mode;
        n_dot    = r_dot;
        n_start  = r_start;
        n_pos    = r_pos;
        n_len    = r_len;
        n_line   = r_line;
        n_prefix = r_prefix;
        n_pend   = r_pend;
        a_vld    = 1'b0;
        b_vld    = 1'b0;
        do_disp  = 1'b0;
        a_tok    = mk_token(K_ERROR, E_NONE, r_start, r_len, r_line);
        b_tok    = mk_token(K_EOF, E_NONE, r_pos, '0, r_line);
        if (r_in_valid && r_in_eos) begin
            // Flush, emit end of file, restart fresh
            case (r_mode)
                M_SLASH: begin
                    a_vld = 1'b1;
                    a_tok = mk_token(K_SLASH, E_NONE, r_start, OFFSET_WIDTH'(1), r_line);
                end
                M_OPER: begin
                    a_vld = 1'b1;
                    a_tok = mk_token(opk, E_NONE, r_start, OFFSET_WIDTH'(1), r_line);
                end
                M_STRING: begin
                    a_vld = 1'b1;
                    a_tok = mk_token(K_ERROR, E_OPEN_STR, r_start, r_len, r_line);
                end
                M_IDENT: begin
                    a_vld = 1'b1;
                    a_tok = mk_token(idk, E_NONE, r_start, r_len, r_line);
                end
                M_NUMBER: begin
                    a_vld = 1'b1;
                    a_tok = mk_token(K_NUMBER, E_NONE, r_start, r_len, r_line);
                end
                M_NUMBER_DOT: begin
                    a_vld = 1'b1;
                    a_tok = mk_token(K_ERROR, E_BAD_NUMBER, r_start, r_len, r_line);
                end
                default: a_vld = 1'b0;
            endcase
            b_vld   = 1'b1;
            n_mode  = M_IDLE;
            n_dot   = 1'b0;
            n_start = '0;
            n_pos   = '0;
            n_len   = '0;
            n_line  = OUT_W'(1);
            n_pend  = OP_BANG;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                n_prefix[j] = 8'h00;
            end
        end else if (r_in_valid) begin
            case (r_mode)
                M_SLASH: begin
                    if (r_in_byte == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        a_vld   = 1'b1;
                        a_tok   = mk_token(K_SLASH, E_NONE, r_start, OFFSET_WIDTH'(1), r_line);
                        do_disp = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (r_in_byte == CH_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                M_OPER: begin
                    a_vld  = 1'b1;
                    n_mode = M_IDLE;
                    if (r_in_byte == "=") begin
                        a_tok = mk_token(opk + 1'b1, E_NONE, r_start, OFFSET_WIDTH'(2), r_line);
                    end else begin
                        a_tok   = mk_token(opk, E_NONE, r_start, OFFSET_WIDTH'(1), r_line);
                        do_disp = 1'b1;
                    end
                end
                M_STRING: begin
                    n_len = inc_sat(r_len);
                    if (r_in_byte == "\"") begin
                        a_vld  = 1'b1;
                        a_tok  = mk_token(K_STRING, E_NONE, r_start, n_len, r_line);
                        n_mode = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(r_in_byte) || is_digit(r_in_byte)) begin
                        if (r_len < OFFSET_WIDTH'(KEYWORD_MAX_LEN)) begin
                            n_prefix[r_len[PIX_W-1:0]] = r_in_byte;
                        end
                        n_len = inc_sat(r_len);
                    end else begin
                        a_vld   = 1'b1;
                        a_tok   = mk_token(idk, E_NONE, r_start, r_len, r_line);
                        do_disp = 1'b1;
                    end
                end
                M_NUMBER, M_NUMBER_DOT: begin
                    if (is_digit(r_in_byte)) begin
                        n_len  = inc_sat(r_len);
                        n_mode = M_NUMBER;
                    end else if (r_in_byte == "." && !r_dot) begin
                        n_dot  = 1'b1;
                        n_len  = inc_sat(r_len);
                        n_mode = M_NUMBER_DOT;
                    end else begin
                        a_vld = 1'b1;
                        if (r_in_byte == "." || r_mode == M_NUMBER_DOT) begin
                            a_tok = mk_token(K_ERROR, E_BAD_NUMBER, r_start, r_len, r_line);
                        end else begin
                            a_tok = mk_token(K_NUMBER, E_NONE, r_start, r_len, r_line);
                        end
                        n_dot   = 1'b0;
                        do_disp = 1'b1;
                    end
                end
                default: do_disp = 1'b1;
            endcase

            // Start a new token at this byte
            if (do_disp) begin
                n_start = r_pos;
                n_len   = OFFSET_WIDTH'(1);
                n_mode  = disp.mode;
                if (disp.mode == M_OPER) begin
                    n_pend = disp.pend;
                end
                if (disp.set_prefix) begin
                    n_prefix[0] = r_in_byte;
                end
                if (disp.clr_dot) begin
                    n_dot = 1'b0;
                end
                b_vld = disp.emit;
                b_tok = mk_token(disp.kind, disp.err, r_pos, OFFSET_WIDTH'(1), r_line);
            end

            // Advance position and line
            if (r_in_byte == CH_LF && r_line != '1) begin
                n_line = r_line + 1'b1;
            end
            n_pos = inc_sat(r_pos);
        end
    end

    // Compact the results and mark the last one
    always_comb begin
        res0  = a_vld ? a_tok : b_tok;
        res1  = b_tok;
        n_res = 2'(a_vld) + 2'(b_vld);
        res0.last = (n_res == 2'd1);
        res1.last = 1'b1;
    end

    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_dot      <= 1'b0;
            r_start    <= '0;
            r_pos      <= '0;
            r_len      <= '0;
            r_line     <= OUT_W'(1);
            r_pend     <= OP_BANG;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                r_prefix[j] <= 8'h00;
            end
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            // Capture the request
            r_in_valid <= s_accept;
            if (s_accept) begin
                r_in_byte <= i_s_axis_tdata;
                r_in_eos  <= i_s_axis_tuser[0];
            end

            // Commit scanner state
            r_mode   <= n_mode;
            r_dot    <= n_dot;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_line   <= n_line;
            r_pend   <= n_pend;
            r_prefix <= n_prefix;

            // Push results, pop the head
            if (n_res != 2'd0) begin
                r_fifo[r_wr_ptr] <= res0;
            end
            if (n_res == 2'd2) begin
                r_fifo[wr_ptr1] <= res1;
            end
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(n_res);
            if (m_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(n_res) - CNT_W'(m_pop);
        end
    end

    // Present the queue head
    assign head            = r_fifo[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {head.line, head.len, head.start};
    assign o_m_axis_tuser  = {head.err, head.kind};
    assign o_m_axis_tlast  = head.last;

endmodule

// ----- src/sts_checker.sv -----
`include "assert_macros.svh"

module sts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    // [15:0] start_offset, [31:16] token_length, [47:32] line_number
    input logic [sts_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    // [5:0] token_kind, [7:6] error_code
    input logic [sts_pkg::OUT_USER_W-1:0] i_m_axis_tuser,
    input logic                           i_m_axis_tlast
);
    import sts_pkg::*;

    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [OUT_W-1:0]  tok_len;
    logic [OUT_W-1:0]  line;

    assign kind    = i_m_axis_tuser[KIND_W-1:0];
    assign err     = i_m_axis_tuser[KIND_W +: ERR_W];
    assign tok_len = i_m_axis_tdata[OUT_W +: OUT_W];
    assign line    = i_m_axis_tdata[2*OUT_W +: OUT_W];

    // Reset empties the result queue
    `STS_ASSERT_NEXT_NORST(a_reset_empty, i_clk, !i_rst_n, !i_m_axis_tvalid)

    // End of file closes the run and spans no bytes
    `STS_ASSERT_IMP(a_eof_last, i_clk, i_rst_n, i_m_axis_tvalid && kind == K_EOF, i_m_axis_tlast && tok_len == '0)

    // Error code is set on error tokens only
    `STS_ASSERT_IMP(a_err_code, i_clk, i_rst_n, i_m_axis_tvalid, (kind == K_ERROR) == (err != E_NONE))

    // Line count starts at one and never wraps to zero
    `STS_ASSERT_IMP(a_line_nonzero, i_clk, i_rst_n, i_m_axis_tvalid, line != '0)

    // Stalled token holds
    `STS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser) && $stable(i_m_axis_tlast))

endmodule

bind script_token_scanner_top sts_checker u_sts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import sts_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_ITEMS = 730;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_LF        = 8'h0A;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam int unsigned OUT_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_SLASH, SCAN_COMMENT, SCAN_OPER,
        SCAN_STRING, SCAN_IDENT, SCAN_NUMBER, SCAN_NUMBER_DOT
    } scan_state_e;

    // Comparison operators in kind order; the "=" form follows each one
    typedef enum logic [1:0] {OP_BANG, OP_EQUAL, OP_GREATER, OP_LESS} oper_e;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  len;
        logic [OUT_W-1:0]  line;
        logic              last;
    } lex_token_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [7:0] source_byte
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // [0] end_of_source
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [15:0] start_offset, [31:16] token_length, [47:32] line_number
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // [5:0] token_kind, [7:6] error_code
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    script_token_scanner_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Keyword spellings in kind order
    string keyword_text [16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                                 "or", "print", "return", "super", "this", "true", "var",
                                 "while"};
    string punct_chars = "(){},.-+;*/";
    string oper_chars  = "!=<>";
    string blank_chars = " \r\n\t";
    string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    // Scanner state mirrored by the token predictor
    scan_state_e             scan_state;
    logic                    dot_seen;
    logic [OFFSET_WIDTH-1:0] token_start;
    logic [OFFSET_WIDTH-1:0] byte_position;
    logic [OFFSET_WIDTH-1:0] token_len;
    logic [OUT_W-1:0]        line_count;
    logic [7:0]              word_prefix [KEYWORD_MAX_LEN];
    oper_e                   oper_index;

    lex_token_t  awaited_tokens [$];
    lex_token_t  step_tokens [$];
    int          errors = 0;
    int          requests_sent = 0;
    int unsigned cycle_count = 0;
    bit          src_pace = 1'b1;
    bit          sink_pace = 1'b1;
    int          hold_requests = 0;
    int          hold_served = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [OFFSET_WIDTH-1:0] sat_inc(logic [OFFSET_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] clip_out(logic [OFFSET_WIDTH-1:0] v);
        return (v > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic void reset_scanner();
        scan_state    = SCAN_IDLE;
        dot_seen      = 1'b0;
        token_start   = '0;
        byte_position = '0;
        token_len     = '0;
        line_count    = OUT_W'(1);
        oper_index    = OP_BANG;
        foreach (word_prefix[i]) word_prefix[i] = 8'h00;
    endfunction

    function automatic void emit_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                       logic [OFFSET_WIDTH-1:0] start,
                                       logic [OFFSET_WIDTH-1:0] len);
        lex_token_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = clip_out(start);
        t.len   = clip_out(len);
        t.line  = line_count;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    // Keyword only on an exact length match against the stored prefix
    function automatic logic [KIND_W-1:0] word_kind();
        bit hit;
        if (token_len > KEYWORD_MAX_LEN) return K_IDENT;
        for (int i = 0; i < 16; i++) begin
            if (keyword_text[i].len() == token_len) begin
                hit = 1'b1;
                for (int j = 0; j < keyword_text[i].len(); j++)
                    if (keyword_text[i][j] != word_prefix[j]) hit = 1'b0;
                if (hit) return KIND_W'(K_KEYWORD_BASE + i);
            end
        end
        return K_IDENT;
    endfunction

    // Open a token on a byte seen between tokens
    function automatic void start_token(logic [7:0] b);
        token_start = byte_position;
        token_len   = OFFSET_WIDTH'(1);
        case (b)
            " ", CH_CR, CH_LF, CH_TAB: ;
            "(": emit_token(K_LPAREN, E_NONE, byte_position, OFFSET_WIDTH'(1));
            ")": emit_token(K_RPAREN, E_NONE, byte_position, OFFSET_WIDTH'(1));
            "{": emit_token(K_LBRACE, E_NONE, byte_position, OFFSET_WIDTH'(1));
            "}": emit_token(K_RBRACE, E_NONE, byte_position, OFFSET_WIDTH'(1));
            ",": emit_token(K_COMMA, E_NONE, byte_position, OFFSET_WIDTH'(1));
            ".": emit_token(K_DOT, E_NONE, byte_position, OFFSET_WIDTH'(1));
            "-": emit_token(K_MINUS, E_NONE, byte_position, OFFSET_WIDTH'(1));
            "+": emit_token(K_PLUS, E_NONE, byte_position, OFFSET_WIDTH'(1));
            ";": emit_token(K_SEMI, E_NONE, byte_position, OFFSET_WIDTH'(1));
            "*": emit_token(K_STAR, E_NONE, byte_position, OFFSET_WIDTH'(1));
            "/": scan_state = SCAN_SLASH;
            "!": begin scan_state = SCAN_OPER; oper_index = OP_BANG; end
            "=": begin scan_state = SCAN_OPER; oper_index = OP_EQUAL; end
            ">": begin scan_state = SCAN_OPER; oper_index = OP_GREATER; end
            "<": begin scan_state = SCAN_OPER; oper_index = OP_LESS; end
            "\"": scan_state = SCAN_STRING;
            default: begin
                if (is_alpha(b)) begin
                    scan_state     = SCAN_IDENT;
                    word_prefix[0] = b;
                end else if (is_digit(b)) begin
                    scan_state = SCAN_NUMBER;
                    dot_seen   = 1'b0;
                end else begin
                    emit_token(K_ERROR, E_UNEXPECTED, byte_position, OFFSET_WIDTH'(1));
                end
            end
        endcase
    endfunction

    // Work out the tokens one accepted request causes and queue them
    function automatic void predict_tokens(logic [7:0] b, logic eos);
        logic [KIND_W-1:0] oper_kind;
        oper_kind = KIND_W'(K_OPER_BASE + 2 * oper_index);
        step_tokens.delete();
        if (eos) begin
            // Flush the open token, then EOF, then start over
            case (scan_state)
                SCAN_SLASH:      emit_token(K_SLASH, E_NONE, token_start, OFFSET_WIDTH'(1));
                SCAN_OPER:       emit_token(oper_kind, E_NONE, token_start, OFFSET_WIDTH'(1));
                SCAN_STRING:     emit_token(K_ERROR, E_OPEN_STR, token_start, token_len);
                SCAN_IDENT:      emit_token(word_kind(), E_NONE, token_start, token_len);
                SCAN_NUMBER:     emit_token(K_NUMBER, E_NONE, token_start, token_len);
                SCAN_NUMBER_DOT: emit_token(K_ERROR, E_BAD_NUMBER, token_start, token_len);
                default: ;
            endcase
            emit_token(K_EOF, E_NONE, byte_position, '0);
            reset_scanner();
        end else begin
            case (scan_state)
                SCAN_SLASH: begin
                    if (b == "/") begin
                        scan_state = SCAN_COMMENT;
                    end else begin
                        emit_token(K_SLASH, E_NONE, token_start, OFFSET_WIDTH'(1));
                        scan_state = SCAN_IDLE;
                        start_token(b);
                    end
                end
                SCAN_COMMENT: begin
                    if (b == CH_LF) scan_state = SCAN_IDLE;
                end
                SCAN_OPER: begin
                    scan_state = SCAN_IDLE;
                    if (b == "=") begin
                        emit_token(oper_kind + 1'b1, E_NONE, token_start, OFFSET_WIDTH'(2));
                    end else begin
                        emit_token(oper_kind, E_NONE, token_start, OFFSET_WIDTH'(1));
                        start_token(b);
                    end
                end
                SCAN_STRING: begin
                    token_len = sat_inc(token_len);
                    if (b == "\"") begin
                        emit_token(K_STRING, E_NONE, token_start, token_len);
                        scan_state = SCAN_IDLE;
                    end
                end
                SCAN_IDENT: begin
                    if (is_alpha(b) || is_digit(b)) begin
                        if (token_len < KEYWORD_MAX_LEN) word_prefix[token_len[PIX_W-1:0]] = b;
                        token_len = sat_inc(token_len);
                    end else begin
                        emit_token(word_kind(), E_NONE, token_start, token_len);
                        scan_state = SCAN_IDLE;
                        start_token(b);
                    end
                end
                SCAN_NUMBER, SCAN_NUMBER_DOT: begin
                    if (is_digit(b)) begin
                        token_len  = sat_inc(token_len);
                        scan_state = SCAN_NUMBER;
                    end else if (b == "." && !dot_seen) begin
                        dot_seen   = 1'b1;
                        token_len  = sat_inc(token_len);
                        scan_state = SCAN_NUMBER_DOT;
                    end else begin
                        // A second dot or a trailing dot makes the number invalid
                        if (b == "." || scan_state == SCAN_NUMBER_DOT)
                            emit_token(K_ERROR, E_BAD_NUMBER, token_start, token_len);
                        else
                            emit_token(K_NUMBER, E_NONE, token_start, token_len);
                        scan_state = SCAN_IDLE;
                        dot_seen   = 1'b0;
                        start_token(b);
                    end
                end
                default: start_token(b);
            endcase
            if (b == CH_LF && line_count != 16'hFFFF) line_count = line_count + 1'b1;
            byte_position = sat_inc(byte_position);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) awaited_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] word_char(bit allow_digit);
        return word_chars[$urandom_range(0, allow_digit ? word_chars.len() - 1 : 52)];
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare each accepted token with the oldest prediction
    always @(posedge i_clk) begin : token_checker
        lex_token_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_tokens.size() == 0) begin
                $error("token_kind: expected none, got %0d", o_m_axis_tuser[KIND_W-1:0]);
                errors++;
            end else begin
                want = awaited_tokens.pop_front();
                check_field("token_kind", want.kind, o_m_axis_tuser[KIND_W-1:0]);
                check_field("error_code", want.err, o_m_axis_tuser[KIND_W +: ERR_W]);
                check_field("start_offset", want.start, o_m_axis_tdata[0 +: OUT_W]);
                check_field("token_length", want.len, o_m_axis_tdata[OUT_W +: OUT_W]);
                check_field("line_number", want.line, o_m_axis_tdata[2 * OUT_W +: OUT_W]);
                check_field("last_of_run", want.last, o_m_axis_tlast);
            end
        end
    end

    // Pace the token sink: random stalls, plus a long hold when a test asks for one
    initial begin : sink_pacer
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = HOLD_CYCLES;
            end else if (stall_left == 0 && sink_pace && $urandom_range(0, 4) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one request, hold it until taken, then predict its tokens
    task automatic send_request(logic [7:0] b, logic eos);
        int gap;
        if (src_pace && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        requests_sent++;
        predict_tokens(b, eos);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(b, 1'b0);
    endtask

    // The byte is ignored on an end request, so drive random bits there
    task automatic send_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_digits();
        repeat ($urandom_range(1, 4)) send_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic send_string_body();
        logic [7:0] c;
        repeat ($urandom_range(0, 6)) begin
            c = ($urandom_range(0, 5) == 0) ? CH_LF : 8'($urandom_range(32, 126));
            if (c == "\"") c = "'";
            send_byte(c);
        end
    endtask

    // Drop valid and wait until every predicted token has come out
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_tokens.size() != 0);
    endtask

    // Mostly well-formed tokens with random content, some noise and broken tokens
    task automatic send_random_token();
        int         pick;
        string      word;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        end else if (pick < 22) begin
            send_byte(oper_chars[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1)) send_byte("=");
        end else if (pick < 34) begin
            send_text(keyword_text[$urandom_range(0, 15)]);
            if ($urandom_range(0, 1)) send_byte(" ");
        end else if (pick < 46) begin
            word = keyword_text[$urandom_range(0, 15)];
            case ($urandom_range(0, 2))
                0: begin
                    send_byte(word_char(1'b0));
                    repeat ($urandom_range(0, 8)) send_byte(word_char(1'b1));
                end
                // One past a keyword, or one short of it
                1: begin
                    send_text(word);
                    send_byte(word_char(1'b1));
                end
                default: send_text(word.substr(0, word.len() - 2));
            endcase
        end else if (pick < 56) begin
            send_digits();
            if ($urandom_range(0, 1)) begin
                send_byte(".");
                send_digits();
            end
        end else if (pick < 60) begin
            // Second dot or trailing dot
            send_digits();
            send_byte(".");
            if ($urandom_range(0, 1)) begin
                send_byte(".");
                send_digits();
            end else begin
                send_byte(";");
            end
        end else if (pick < 67) begin
            send_byte("\"");
            send_string_body();
            send_byte("\"");
        end else if (pick < 73) begin
            send_text("//");
            repeat ($urandom_range(0, 8)) begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_LF) c = " ";
                send_byte(c);
            end
            if ($urandom_range(0, 7) != 0) send_byte(CH_LF);
        end else if (pick < 85) begin
            send_byte(blank_chars[$urandom_range(0, 3)]);
        end else if (pick < 92) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
            send_byte("\"");
            send_string_body();
            send_end();
        end else begin
            send_end();
        end
    endtask

    // Two-byte operator, number with a dot, comment, newline, open string at end;
    // then doubled dot, trailing dot, bang-equal, lone slash and out-of-range bytes
    task automatic test_directed_tokens();
        send_text("a<=1.5//c\n\"x");
        send_end();
        send_text("1..2 3. !=/x");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_end();
        wait_drained();
    endtask

    // Hold off the sink while requests keep coming, so the result queue fills up
    task automatic test_backpressure();
        src_pace = 1'b0;
        hold_requests++;
        repeat (10) send_text("a(b)");
        send_end();
        wait_drained();
        src_pace = 1'b1;
    endtask

    task automatic test_random_stream();
        int stop_at;
        stop_at = requests_sent + RANDOM_ITEMS;
        while (requests_sent < stop_at) begin
            // Switch pacing now and then, leaving stretches with no gaps
            if ($urandom_range(0, 59) == 0) begin
                src_pace  = $urandom_range(0, 3) != 0;
                sink_pace = $urandom_range(0, 3) != 0;
            end
            send_random_token();
        end
        send_end();
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_scanner();
        test_directed_tokens();
        test_backpressure();
        test_random_stream();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/sts_pkg.sv
src/script_token_scanner_top.sv
src/sts_checker.sv
tb/sv/tb_top.sv
